// ===== hw/rtl/http_request_line_parser_core_assert.svh =====
// Assertion macros for the port-level checker of the request line parser.
`ifndef HTTP_REQUEST_LINE_PARSER_CORE_ASSERT_SVH
`define HTTP_REQUEST_LINE_PARSER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRLP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("hrlp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HRLP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("hrlp: next-cycle check failed");

`endif

// ===== hw/rtl/hrlp_pkg.sv =====
// Package with types, constants and codes of the request line parser.
package hrlp_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_TWO     = 8'h32;
	localparam logic [7:0] CH_QMARK   = 8'h3F;

	localparam int METHOD_LEN  = 3;
	localparam int VERSION_LEN = 8;

	localparam logic [7:0] METHOD_TEXT [METHOD_LEN] = '{8'h47, 8'h45, 8'h54};
	localparam logic [7:0] VERSION_TEXT [VERSION_LEN] =
		'{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h31};

	localparam logic [1:0] TOK_METHOD  = 2'd1;
	localparam logic [1:0] TOK_TARGET  = 2'd2;
	localparam logic [1:0] TOK_VERSION = 2'd3;

	localparam logic [3:0] POS_MAX = 4'd15;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_PATH  = 2'd1,
		KIND_QUERY = 2'd2
	} kind_e;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_REQUEST = 3'd1,
		ST_NOT_ALLOWED = 3'd2,
		ST_NOT_IMPL    = 3'd3,
		ST_VERSION     = 3'd4
	} status_e;

	typedef struct packed {
		logic [7:0]             byte_val;
		logic                   last;
		logic                   is_space;
		logic                   is_slash;
		logic                   is_pct;
		logic                   is_two;
		logic                   is_qmark;
		logic [METHOD_LEN-1:0]  method_hit;
		logic [VERSION_LEN-1:0] version_hit;
	} item_cls_t;

endpackage

// ===== hw/rtl/hrlp_front.sv =====
// Front end: classifies each incoming byte against the protocol characters.
module hrlp_front (
	input  logic               in_valid,
	input  logic [7:0]         line_byte,
	input  logic               last_byte,
	input  logic               queue_full,
	output logic               in_ready,
	output logic               push,
	output hrlp_pkg::item_cls_t push_item
);
	import hrlp_pkg::*;

	assign in_ready = !queue_full;
	assign push     = in_valid && !queue_full;

	always_comb begin
		push_item          = '0;
		push_item.byte_val = line_byte;
		push_item.last     = last_byte;
		push_item.is_space = (line_byte == CH_SPACE);
		push_item.is_slash = (line_byte == CH_SLASH);
		push_item.is_pct   = (line_byte == CH_PERCENT);
		push_item.is_two   = (line_byte == CH_TWO);
		push_item.is_qmark = (line_byte == CH_QMARK);
		for (int i = 0; i < METHOD_LEN; i++) begin
			push_item.method_hit[i] = (line_byte == METHOD_TEXT[i]);
		end
		for (int i = 0; i < VERSION_LEN; i++) begin
			push_item.version_hit[i] = (line_byte == VERSION_TEXT[i]);
		end
	end

endmodule

// ===== hw/rtl/hrlp_queue.sv =====
// Short queue of classified items between the front and back ends.
module hrlp_queue #(
	parameter int DEPTH = hrlp_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hrlp_pkg::item_cls_t push_item,
	input  logic                pop,
	output logic                full,
	output logic                not_empty,
	output hrlp_pkg::item_cls_t head_item
);
	import hrlp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_cls_t         entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head_item = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/hrlp_back.sv =====
// Back end: token tracking, checks, byte streaming and the output register.
module hrlp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_avail,
	input  hrlp_pkg::item_cls_t item,
	output logic                pop,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [7:0]          out_byte,
	output logic [1:0]          out_kind,
	output logic                line_done,
	output logic [2:0]          status
);
	import hrlp_pkg::*;

	logic [1:0] tc_q, tc_d;
	logic       ins_q, ins_d;
	logic [3:0] pos_q, pos_d;
	logic       mm_q, mm_d;
	logic       slash_q, slash_d;
	logic [1:0] qp_q, qp_d;
	logic       qf_q, qf_d;
	logic       pq_q, pq_d;
	logic       vm_q, vm_d;
	kind_e      kind_d;
	status_e    status_d;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	kind_e      out_kind_q;
	logic       line_done_q;
	status_e    status_q;

	assign pop       = item_avail && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_kind  = out_kind_q;
	assign line_done = line_done_q;
	assign status    = status_q;

	always_comb begin
		tc_d     = tc_q;
		ins_d    = ins_q;
		pos_d    = pos_q;
		mm_d     = mm_q;
		slash_d  = slash_q;
		qp_d     = qp_q;
		qf_d     = qf_q;
		pq_d     = pq_q;
		vm_d     = vm_q;
		kind_d   = KIND_NONE;
		status_d = ST_OK;

		if (item.is_space) begin
			if (ins_d) begin
				if (tc_d == TOK_METHOD && pos_d != 4'(METHOD_LEN)) mm_d = 1'b0;
				if (tc_d == TOK_VERSION && pos_d < 4'(VERSION_LEN)) vm_d = 1'b0;
			end
			ins_d = 1'b0;
			pos_d = '0;
		end else begin
			if (!ins_d && tc_d != TOK_VERSION) begin
				tc_d  = tc_d + 2'd1;
				ins_d = 1'b1;
				pos_d = '0;
			end
			if (ins_d) begin
				if (tc_d == TOK_METHOD) begin
					if (pos_d >= 4'(METHOD_LEN) || !item.method_hit[pos_d[1:0]]) mm_d = 1'b0;
				end else if (tc_d == TOK_TARGET) begin
					if (pos_d == '0 && item.is_slash) slash_d = 1'b1;
					if (item.is_pct) begin
						qp_d = 2'd1;
					end else if (item.is_two && qp_d == 2'd1) begin
						qp_d = 2'd2;
					end else if (item.is_two && qp_d == 2'd2) begin
						qf_d = 1'b1;
						qp_d = 2'd0;
					end else begin
						qp_d = 2'd0;
					end
					if (pq_d) begin
						kind_d = KIND_QUERY;
					end else if (item.is_qmark) begin
						pq_d = 1'b1;
					end else begin
						kind_d = KIND_PATH;
					end
				end else begin
					if (pos_d < 4'(VERSION_LEN) && !item.version_hit[pos_d[2:0]]) vm_d = 1'b0;
				end
				if (pos_d != POS_MAX) pos_d = pos_d + 4'd1;
			end
		end

		if (item.last) begin
			if (ins_d) begin
				if (tc_d == TOK_METHOD && pos_d != 4'(METHOD_LEN)) mm_d = 1'b0;
				if (tc_d == TOK_VERSION && pos_d < 4'(VERSION_LEN)) vm_d = 1'b0;
			end
			if (tc_d != TOK_VERSION) status_d = ST_BAD_REQUEST;
			else if (!mm_d)          status_d = ST_NOT_ALLOWED;
			else if (!slash_d)       status_d = ST_NOT_IMPL;
			else if (qf_d)           status_d = ST_BAD_REQUEST;
			else if (!vm_d)          status_d = ST_VERSION;
			else                     status_d = ST_OK;
			tc_d    = '0;
			ins_d   = 1'b0;
			pos_d   = '0;
			mm_d    = 1'b1;
			slash_d = 1'b0;
			qp_d    = '0;
			qf_d    = 1'b0;
			pq_d    = 1'b0;
			vm_d    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q        <= '0;
			ins_q       <= 1'b0;
			pos_q       <= '0;
			mm_q        <= 1'b1;
			slash_q     <= 1'b0;
			qp_q        <= '0;
			qf_q        <= 1'b0;
			pq_q        <= 1'b0;
			vm_q        <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				tc_q        <= tc_d;
				ins_q       <= ins_d;
				pos_q       <= pos_d;
				mm_q        <= mm_d;
				slash_q     <= slash_d;
				qp_q        <= qp_d;
				qf_q        <= qf_d;
				pq_q        <= pq_d;
				vm_q        <= vm_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_byte_q  <= (kind_d != KIND_NONE) ? item.byte_val : 8'd0;
			out_kind_q  <= kind_d;
			line_done_q <= item.last;
			status_q    <= status_d;
		end
	end

endmodule

// ===== hw/rtl/http_request_line_parser_core.sv =====
// Top level of the request line parser: front end, item queue and back end.
// An accepted byte is written into the queue, then popped into the back end's output register.
// Throughput: one byte per cycle while the output is not stalled, set by the per-byte state update in the back end.
// The queue absorbs up to QueueDepth bytes while the output is stalled.
// Reset is asynchronous and active low; it empties the queue and output register
// and returns the token state to the start of a line.
module http_request_line_parser_core #(
	parameter int QueueDepth = hrlp_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] line_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] out_kind,
	output logic       line_done,
	output logic [2:0] status
);
	import hrlp_pkg::*;

	logic      push;
	logic      pop;
	logic      queue_full;
	logic      queue_avail;
	item_cls_t push_item;
	item_cls_t head_item;

	hrlp_front u_front (
		.in_valid   (in_valid),
		.line_byte  (line_byte),
		.last_byte  (last_byte),
		.queue_full (queue_full),
		.in_ready   (in_ready),
		.push       (push),
		.push_item  (push_item)
	);

	hrlp_queue #(
		.DEPTH (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (queue_avail),
		.head_item (head_item)
	);

	hrlp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_avail (queue_avail),
		.item       (head_item),
		.pop        (pop),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.out_byte   (out_byte),
		.out_kind   (out_kind),
		.line_done  (line_done),
		.status     (status)
	);

endmodule

// ===== hw/rtl/hrlp_checker.sv =====
// Port-level checker of the request line parser and its bind statement.
`include "http_request_line_parser_core_assert.svh"

module hrlp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic [1:0] out_kind,
	input logic       line_done,
	input logic [2:0] status
);
	import hrlp_pkg::*;

	`HRLP_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_byte) && $stable(out_kind) && $stable(line_done) && $stable(status))
	`HRLP_ASSERT_IMP(a_no_byte_zero, clk, arst_n, out_valid && out_kind == KIND_NONE, out_byte == 8'd0)
	`HRLP_ASSERT_IMP(a_status_only_done, clk, arst_n, out_valid && !line_done, status == ST_OK)
	`HRLP_ASSERT_IMP(a_codes_legal, clk, arst_n, out_valid,
		(out_kind == KIND_NONE || out_kind == KIND_PATH || out_kind == KIND_QUERY) &&
		(status == ST_OK || status == ST_BAD_REQUEST || status == ST_NOT_ALLOWED ||
		status == ST_NOT_IMPL || status == ST_VERSION))

endmodule

bind http_request_line_parser_core hrlp_checker u_hrlp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.out_kind  (out_kind),
	.line_done (line_done),
	.status    (status)
);

// ===== test/http_request_line_parser_core_check.sv =====
// Monitor for the request line parser: predicts each result from accepted bytes and compares.
module http_request_line_parser_core_check (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] line_byte,
	input  logic       last_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic [1:0] out_kind,
	input  logic       line_done,
	input  logic [2:0] status,
	output int         fail_count,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import hrlp_pkg::*;

	typedef struct packed {
		logic [7:0] byte_val;
		kind_e      kind;
		logic       done;
		status_e    verdict;
	} parse_res_t;

	parse_res_t parse_results_q[$];
	int         n_err;

	logic [1:0] tok_cnt;
	logic       in_tok;
	logic [3:0] pos;
	logic       meth_ok;
	logic       slash_seen;
	logic [1:0] pct_stage;
	logic       pct22_seen;
	logic       in_query;
	logic       ver_ok;

	task automatic clear_line_state();
		tok_cnt = '0;
		in_tok = 1'b0;
		pos = '0;
		meth_ok = 1'b1;
		slash_seen = 1'b0;
		pct_stage = '0;
		pct22_seen = 1'b0;
		in_query = 1'b0;
		ver_ok = 1'b1;
	endtask

	task automatic close_token();
		if (in_tok) begin
			if (tok_cnt == TOK_METHOD && pos != 4'(METHOD_LEN))
				meth_ok = 1'b0;
			if (tok_cnt == TOK_VERSION && pos < 4'(VERSION_LEN))
				ver_ok = 1'b0;
		end
		in_tok = 1'b0;
		pos = '0;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic lst, output parse_res_t r);
		kind_e   k;
		status_e st;
		k = KIND_NONE;
		st = ST_OK;
		if (b == CH_SPACE) begin
			close_token();
		end else begin
			if (!in_tok && tok_cnt < TOK_VERSION) begin
				tok_cnt++;
				in_tok = 1'b1;
				pos = '0;
			end
			if (in_tok) begin
				case (tok_cnt)
					TOK_METHOD: begin
						if (pos >= 4'(METHOD_LEN))
							meth_ok = 1'b0;
						else if (b != METHOD_TEXT[pos])
							meth_ok = 1'b0;
					end
					TOK_TARGET: begin
						if (pos == 0 && b == CH_SLASH)
							slash_seen = 1'b1;
						if (b == CH_PERCENT) begin
							pct_stage = 2'd1;
						end else if (b == CH_TWO && pct_stage == 2'd1) begin
							pct_stage = 2'd2;
						end else if (b == CH_TWO && pct_stage == 2'd2) begin
							pct22_seen = 1'b1;
							pct_stage = 2'd0;
						end else begin
							pct_stage = 2'd0;
						end
						if (in_query)
							k = KIND_QUERY;
						else if (b == CH_QMARK)
							in_query = 1'b1;
						else
							k = KIND_PATH;
					end
					default: begin
						if (pos < 4'(VERSION_LEN)) begin
							if (b != VERSION_TEXT[pos[2:0]])
								ver_ok = 1'b0;
						end
					end
				endcase
				if (pos < POS_MAX)
					pos++;
			end
		end
		if (lst) begin
			close_token();
			if (tok_cnt < TOK_VERSION)
				st = ST_BAD_REQUEST;
			else if (!meth_ok)
				st = ST_NOT_ALLOWED;
			else if (!slash_seen)
				st = ST_NOT_IMPL;
			else if (pct22_seen)
				st = ST_BAD_REQUEST;
			else if (!ver_ok)
				st = ST_VERSION;
			else
				st = ST_OK;
			clear_line_state();
		end
		r.byte_val = (k != KIND_NONE) ? b : 8'h00;
		r.kind = k;
		r.done = lst;
		r.verdict = st;
	endtask

	task automatic check_field(input string field, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
			n_err++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		parse_res_t want;
		if (!arst_n) begin
			parse_results_q.delete();
			clear_line_state();
			n_err = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (parse_results_q.size() == 0) begin
					$display({"%0t: unexpected item, expected none, ",
						"got byte %0d kind %0d done %0d status %0d"},
						$time, out_byte, out_kind, line_done, status);
					n_err++;
				end else begin
					want = parse_results_q.pop_front();
					check_field("out_byte", want.byte_val, out_byte);
					check_field("out_kind", 8'(want.kind), 8'(out_kind));
					check_field("line_done", 8'(want.done), 8'(line_done));
					check_field("status", 8'(want.verdict), 8'(status));
				end
			end
			if (in_valid && in_ready) begin
				parse_byte(line_byte, last_byte, want);
				parse_results_q.push_back(want);
			end
			pending <= parse_results_q.size();
			fail_count <= n_err;
		end
	end

endmodule

// ===== test/http_request_line_parser_core_tb.sv =====
// Testbench top for the request line parser: drives request lines with gaps, gives the verdict.
module http_request_line_parser_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hrlp_pkg::*;

	localparam int RANDOM_ITEMS = 400;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] line_byte;
	logic       last_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic [1:0] out_kind;
	logic       line_done;
	logic [2:0] status;
	int         fail_count;
	int         pending;

	logic [7:0] line_q[$];
	int         items_sent = 0;
	bit         quiet = 1'b0;
	bit         held_off = 1'b0;
	int         cycles = 0;

	http_request_line_parser_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.line_byte (line_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_kind  (out_kind),
		.line_done (line_done),
		.status    (status)
	);

	http_request_line_parser_core_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.line_byte  (line_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_kind   (out_kind),
		.line_done  (line_done),
		.status     (status),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] tok_byte();
		logic [7:0] b;
		if ($urandom_range(0, 3) == 0)
			b = 8'($urandom_range(0, 255));
		else
			b = 8'($urandom_range(33, 126));
		if (b == CH_SPACE)
			b = 8'h00;
		return b;
	endfunction

	function automatic logic [7:0] target_byte();
		case ($urandom_range(0, 7))
			0: return CH_QMARK;
			1: return CH_PERCENT;
			2: return CH_TWO;
			default: return tok_byte();
		endcase
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_q.push_back(s[i]);
	endtask

	task automatic add_spaces();
		repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1)
			line_q.push_back(CH_SPACE);
	endtask

	task automatic add_tok_bytes(input int n);
		repeat (n)
			line_q.push_back(tok_byte());
	endtask

	task automatic build_random_line();
		int shape;
		int idx;
		line_q.delete();
		shape = $urandom_range(0, 9);
		if (shape == 0) begin
			repeat ($urandom_range(1, 12))
				line_q.push_back(8'($urandom_range(0, 255)));
			return;
		end
		if ($urandom_range(0, 7) == 0)
			add_spaces();
		case ($urandom_range(0, 9))
			0: add_text("GE");
			1: add_text("GETT");
			2: add_tok_bytes($urandom_range(1, 5));
			default: add_text("GET");
		endcase
		add_spaces();
		if ($urandom_range(0, 7) != 0)
			line_q.push_back(CH_SLASH);
		repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 5))
			line_q.push_back(target_byte());
		if ($urandom_range(0, 5) == 0)
			add_text("%22");
		if (shape != 1) begin
			add_spaces();
			case ($urandom_range(0, 7))
				0: add_text("HTTP/1.0");
				1: add_text("HTTP/1.");
				2: add_text("HTTP/1.10");
				3: begin
					add_text("HTTP/1.1");
					idx = line_q.size() - 1 - $urandom_range(0, 7);
					line_q[idx] = line_q[idx] ^ 8'h01;
				end
				default: add_text("HTTP/1.1");
			endcase
			if ($urandom_range(0, 5) == 0) begin
				add_spaces();
				add_tok_bytes($urandom_range(1, 6));
			end
			if ($urandom_range(0, 5) == 0)
				add_spaces();
		end
		if ($urandom_range(0, 5) != 0) begin
			line_q.push_back(CH_CR);
			line_q.push_back(CH_LF);
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic lst);
		int gap;
		gap = quiet ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		line_byte <= b;
		last_byte <= lst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_line();
		for (int i = 0; i < line_q.size(); i++)
			send_byte(line_q[i], i == line_q.size() - 1);
	endtask

	initial begin
		int run;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_off && items_sent >= 80) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			if (!quiet) begin
				run = gap_len();
				if (run > 0) begin
					out_ready <= 1'b0;
					repeat (run) @(posedge clk);
				end
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("http_request_line_parser_core_tb: done, errors");
		$finish;
	end

	initial begin
		int directed_end;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		line_byte <= 8'h00;
		last_byte <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		line_q.delete();
		line_q.push_back(8'hFF);
		send_line();
		line_q.delete();
		add_text("GET /?q? HTTP/1.1");
		send_line();
		line_q.delete();
		add_text("a /%22");
		send_line();
		directed_end = items_sent;

		while (items_sent < directed_end + RANDOM_ITEMS) begin
			quiet = (items_sent >= 180 && items_sent < 260);
			build_random_line();
			send_line();
		end
		quiet = 1'b0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("http_request_line_parser_core_tb: done, clean");
		else
			$display("http_request_line_parser_core_tb: done, errors");
		$finish;
	end

endmodule
